[design/assert_macros.svh]
// assertion macros used by the tracker design
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/trk_pkg.sv]
// types, constants and codes of the unacked segment tracker
// no dependencies
`timescale 1ns / 1ps

package trk_pkg;

	localparam int ENTRIES = 8;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [3:0]  IP_VERSION   = 4'd4;
	localparam logic [15:0] MIN_FRAME    = 16'd40;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [15:0] ETH_HDR      = 16'd14;
	localparam logic [15:0] EXPIRE_RESET = 16'd30;
	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_ACK = 4;

	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-1:0] ADDR_EXPIRE = 3'd0;

	typedef enum logic [1:0] {
		CMD_PKT   = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		INS_NONE    = 3'd0,
		INS_UPDATED = 3'd1,
		INS_NOT_ADV = 3'd2,
		INS_CREATED = 3'd3,
		INS_FULL    = 3'd4
	} ins_t;

	typedef enum logic [1:0] {
		ACK_NONE     = 2'd0,
		ACK_REMOVED  = 2'd1,
		ACK_MISMATCH = 2'd2,
		ACK_NO_ENTRY = 2'd3
	} ack_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_P1,
		ST_P2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  ver_ihl;
		logic [7:0]  protocol;
		logic [15:0] frame_length;
		logic [15:0] tcp_offset_flags;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [31:0] time_sec;
	} in_word_t;

	typedef struct packed {
		logic        filtered;
		logic [2:0]  insert_status;
		logic [1:0]  ack_status;
		logic        expired;
		logic [3:0]  live_count;
		logic [3:0]  used_count;
	} out_word_t;

	typedef struct packed {
		logic [31:0] key_sa;
		logic [31:0] key_da;
		logic [15:0] key_sp;
		logic [15:0] key_dp;
		logic [31:0] new_end;
		logic [31:0] now;
		logic [15:0] expire;
		logic        do_tick;
		logic        do_clear;
	} cell_ctl_t;

	typedef struct packed {
		logic        hit;
		logic        first_free;
		logic        valid;
		logic        exp_hit;
		logic [31:0] end_seq;
	} cell_stat_t;

endpackage

[design/trk_if.sv]
// valid/ready channels carrying tracker input and result words
// depends on trk_pkg
`timescale 1ns / 1ps

interface trk_in_if import trk_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trk_out_if import trk_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/trk_cell.sv]
// one table entry: flow key, end sequence, time and valid bit
// depends on trk_pkg; free-slot search ripples from cell to cell
`timescale 1ns / 1ps

module trk_cell import trk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  logic       in_range,
	input  logic       free_in,
	input  logic       wr_new,
	input  logic       wr_upd,
	input  logic       wr_kill,
	output logic       free_out,
	output cell_stat_t stat
);

	logic [31:0] sa_q, da_q, end_q, time_q;
	logic [15:0] sp_q, dp_q;
	logic        valid_q;
	logic        is_free;
	logic [31:0] age;

	always_comb begin
		is_free         = !valid_q && in_range;
		age             = ctl.now - time_q;
		free_out        = free_in || is_free;
		stat.hit        = valid_q && in_range && sa_q == ctl.key_sa && da_q == ctl.key_da
			&& sp_q == ctl.key_sp && dp_q == ctl.key_dp;
		stat.first_free = is_free && !free_in;
		stat.valid      = valid_q;
		stat.exp_hit    = ctl.do_tick && valid_q && in_range && time_q <= ctl.now
			&& age > {16'd0, ctl.expire};
		stat.end_seq    = end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.do_clear) begin
			valid_q <= 1'b0;
		end else if (wr_new) begin
			valid_q <= 1'b1;
		end else if (wr_kill || stat.exp_hit) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_new) begin
			sa_q <= ctl.key_sa;
			da_q <= ctl.key_da;
			sp_q <= ctl.key_sp;
			dp_q <= ctl.key_dp;
		end
		if (wr_new || wr_upd) begin
			end_q  <= ctl.new_end;
			time_q <= ctl.now;
		end
	end

endmodule

[design/tcp_unacked_segment_tracker.sv]
// Tracks TCP flows with unacknowledged data in a row of ENTRIES cells. A word passes from
// acceptance through the insert pass, the ACK pass and the count and output state into the
// result register, and the next word is taken in the cycle after the result has been delivered,
// so a new word is never taken while the last one is in flight; the ACK pass must see the table
// as the insert pass left it, and the result register holds one word. expire_seconds sits at
// byte address 0 of the APB port. There is no clearing pass after reset.
// depends on trk_pkg, trk_if, trk_cell and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcp_unacked_segment_tracker import trk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	trk_in_if.sink            in,
	trk_out_if.source         out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	state_t      state_q, state_d;
	in_word_t    in_q;
	logic [CNT_W-1:0] used_q, used_d, last_valid, live;
	logic [15:0] expire_q;
	logic        filt_q, exp_q, out_valid_q;
	logic [2:0]  ins_q, ins_d;
	logic [1:0]  ack_q, ack_d;
	out_word_t   out_q;

	cell_ctl_t   ctl;
	cell_stat_t  stat [ENTRIES];
	logic [ENTRIES:0]   free_chain;
	logic [ENTRIES-1:0] in_range, at_used, hit_v, first_v, valid_v, exp_v;
	logic [ENTRIES-1:0] wr_new, wr_upd, wr_kill;

	logic        filt, hit_any, free_any;
	logic [15:0] payload;
	logic [31:0] end_sel;
	logic [7:0]  cnt_ext, used_ext;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_EXPIRE[2]) ? {16'd0, expire_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expire_q <= EXPIRE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_EXPIRE[2]) begin
			expire_q <= pwdata[15:0];
		end
	end

	// packet decode
	always_comb begin
		filt = in_q.ver_ihl[7:4] != IP_VERSION || in_q.frame_length < MIN_FRAME
			|| in_q.protocol != PROTO_TCP;
		if (in_q.tcp_offset_flags[FLAG_FIN] || in_q.tcp_offset_flags[FLAG_SYN]) begin
			payload = 16'd1;
		end else begin
			payload = in_q.frame_length - {10'd0, in_q.tcp_offset_flags[15:12], 2'b00}
				- {10'd0, in_q.ver_ihl[3:0], 2'b00} - ETH_HDR;
		end
	end

	// cell row
	always_comb begin
		ctl.key_sa   = (state_q == ST_P2) ? in_q.dst_addr : in_q.src_addr;
		ctl.key_da   = (state_q == ST_P2) ? in_q.src_addr : in_q.dst_addr;
		ctl.key_sp   = (state_q == ST_P2) ? in_q.dst_port : in_q.src_port;
		ctl.key_dp   = (state_q == ST_P2) ? in_q.src_port : in_q.dst_port;
		ctl.new_end  = in_q.seq_num + {16'd0, payload};
		ctl.now      = in_q.time_sec;
		ctl.expire   = expire_q;
		ctl.do_tick  = state_q == ST_P1 && in_q.command == CMD_TICK;
		ctl.do_clear = state_q == ST_P1 && in_q.command == CMD_CLEAR;
	end

	assign free_chain[0] = 1'b0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		assign in_range[i] = CNT_W'(i) < used_q;
		assign at_used[i]  = CNT_W'(i) == used_q;
		trk_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_range (in_range[i]),
			.free_in  (free_chain[i]),
			.wr_new   (wr_new[i]),
			.wr_upd   (wr_upd[i]),
			.wr_kill  (wr_kill[i]),
			.free_out (free_chain[i+1]),
			.stat     (stat[i])
		);
		assign hit_v[i]   = stat[i].hit;
		assign first_v[i] = stat[i].first_free;
		assign valid_v[i] = stat[i].valid;
		assign exp_v[i]   = stat[i].exp_hit;
	end

	always_comb begin
		end_sel    = 32'd0;
		last_valid = '0;
		live       = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_v[i]) end_sel = end_sel | stat[i].end_seq;
			if (valid_v[i] && in_range[i]) last_valid = CNT_W'(i + 1);
			live = live + CNT_W'(valid_v[i]);
		end
		hit_any  = |hit_v;
		free_any = free_chain[ENTRIES];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		used_d  = used_q;
		ins_d   = ins_q;
		ack_d   = ack_q;
		wr_new  = '0;
		wr_upd  = '0;
		wr_kill = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in.valid && in.ready) state_d = ST_P1;
			end
			ST_P1: begin
				state_d = ST_P2;
				ins_d   = INS_NONE;
				if (in_q.command == CMD_PKT && !filt && payload != 16'd0) begin
					if (hit_any) begin
						if (ctl.new_end > end_sel) begin
							wr_upd = hit_v;
							ins_d  = INS_UPDATED;
						end else begin
							ins_d = INS_NOT_ADV;
						end
					end else if (free_any) begin
						wr_new = first_v;
						ins_d  = INS_CREATED;
					end else if (used_q < CNT_W'(ENTRIES)) begin
						wr_new = at_used;
						used_d = used_q + 1'b1;
						ins_d  = INS_CREATED;
					end else begin
						ins_d = INS_FULL;
					end
				end else if (in_q.command == CMD_TICK) begin
					if (exp_v == '0) used_d = last_valid;
				end else if (in_q.command == CMD_CLEAR) begin
					used_d = '0;
				end
			end
			ST_P2: begin
				state_d = ST_DONE;
				ack_d   = ACK_NONE;
				if (in_q.command == CMD_PKT && !filt && in_q.tcp_offset_flags[FLAG_ACK]) begin
					if (!hit_any) begin
						ack_d = ACK_NO_ENTRY;
					end else if (in_q.ack_num == end_sel) begin
						wr_kill = hit_v;
						ack_d   = ACK_REMOVED;
					end else begin
						ack_d = ACK_MISMATCH;
					end
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cnt_ext  = 8'(live);
	assign used_ext = 8'(used_q);

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) in_q <= in.data;
		ins_q <= ins_d;
		ack_q <= ack_d;
		if (state_q == ST_P1) begin
			filt_q <= in_q.command == CMD_PKT && filt;
			exp_q  <= in_q.command == CMD_TICK && exp_v != '0;
		end
		if (state_q == ST_DONE) begin
			out_q.filtered      <= filt_q;
			out_q.insert_status <= ins_q;
			out_q.ack_status    <= ack_q;
			out_q.expired       <= exp_q;
			out_q.live_count    <= cnt_ext[3:0];
			out_q.used_count    <= used_ext[3:0];
		end
	end

	assign in.ready  = state_q == ST_IDLE && !out_valid_q;
	assign out.valid = out_valid_q;
	assign out.data  = out_q;

	`ASSERT_ALWAYS(a_ready_excl, clk, arst_n, !(in.ready && out_valid_q))
	`ASSERT_ALWAYS(a_used_bound, clk, arst_n, used_q <= CNT_W'(ENTRIES))
	`ASSERT_ALWAYS(a_valid_in_range, clk, arst_n, (valid_v & ~in_range) == '0)
	`ASSERT_IMPL(a_accept_starts, clk, arst_n, in.valid && in.ready, state_q == ST_P1)

endmodule
